FILE: hw/rtl/ort_pkg.sv
package ort_pkg;
	localparam int ENTRIES = 16;
	localparam int OP_WIDTH = 8;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int QDEPTH = 2;

	localparam logic [1:0] ACT_PUT = 2'd0;
	localparam logic [1:0] ACT_GET = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;
	localparam logic [1:0] ACT_FLUSH = 2'd3;

	localparam logic [1:0] CLASS_BAD = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_NONE = 3'd2;
	localparam logic [2:0] ST_BADCLASS = 3'd3;
	localparam logic [2:0] ST_ABORTED = 3'd4;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] req_class;
		logic bad;
		logic [63:0] call_id;
		logic [7:0] opcode;
		logic [31:0] frame_handle;
		logic [31:0] now_sec;
	} cmd_t;

	typedef struct packed {
		logic [1:0] cls;
		logic [63:0] call_id;
		logic [7:0] opcode;
		logic [31:0] handle;
		logic [31:0] stamp;
	} slot_t;
endpackage

FILE: hw/rtl/ort_front.sv
module ort_front import ort_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [1:0] req_class,
	input logic [63:0] call_id,
	input logic [7:0] opcode,
	input logic [31:0] frame_handle,
	input logic [31:0] now_sec,
	output logic q_valid,
	input logic q_pop,
	output cmd_t q_cmd
);
	cmd_t buf_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wr_q, rd_q;
	logic [$clog2(QDEPTH):0] fill_q;
	logic push;
	cmd_t c;

	always_comb begin
		c.action = action;
		c.req_class = req_class;
		c.bad = (req_class == CLASS_BAD);
		c.call_id = call_id;
		c.opcode = opcode & 8'((64'd1 << OP_WIDTH) - 64'd1);
		c.frame_handle = frame_handle;
		c.now_sec = now_sec;
	end

	assign in_stall = (fill_q == ($clog2(QDEPTH)+1)'(QDEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (fill_q != '0);
	assign q_cmd = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			fill_q <= fill_q + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(q_pop);
		end
	end
endmodule

FILE: hw/rtl/ort_back.sv
module ort_back import ort_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [31:0] timeout_sec,
	input logic q_valid,
	output logic q_pop,
	input cmd_t q_cmd,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [31:0] out_handle,
	output logic [7:0] out_opcode,
	output logic [63:0] out_call_id,
	output logic [1:0] out_class,
	output logic [4:0] pending_count,
	output logic last
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_EMIT = 3'd3;

	slot_t slot_q [ENTRIES];
	logic [CNT_W-1:0] count_q;
	logic [2:0] state_q;
	cmd_t cmd_q;
	logic [CNT_W-1:0] scan_q;
	logic found_q, flushed_q;
	slot_t hit_slot_q;
	logic [IDX_W-1:0] sidx;
	logic match;

	// Final result pending of the current flush is held back until the scan
	// shows whether another entry of the class follows.
	logic held_q;
	slot_t held_slot_q;

	assign sidx = scan_q[IDX_W-1:0];
	assign match = (slot_q[sidx].cls == cmd_q.req_class) &&
		(cmd_q.action != ACT_GET || slot_q[sidx].call_id == cmd_q.call_id);
	assign q_pop = (state_q == S_IDLE) && q_valid && (!out_valid || !out_stall);

	logic free;
	assign free = !out_valid || !out_stall;

	// A new result is loaded into the output register in this cycle.
	logic res_load;
	assign res_load = (q_pop && (q_cmd.bad || q_cmd.action == ACT_PUT)) ||
		(state_q == S_EMIT && free &&
		!(cmd_q.action == ACT_FLUSH && found_q && !held_q));

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_pop && !q_cmd.bad && q_cmd.action == ACT_PUT &&
			count_q != CNT_W'(ENTRIES)) begin
			slot_q[count_q[IDX_W-1:0]] <= '{q_cmd.req_class, q_cmd.call_id, q_cmd.opcode,
				q_cmd.frame_handle, q_cmd.now_sec};
		end else if (state_q == S_SHIFT && scan_q + 1'b1 < count_q) begin
			slot_q[sidx] <= slot_q[IDX_W'(scan_q + 1'b1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
			held_q <= 1'b0;
		end else begin
			out_valid <= res_load || (out_valid && out_stall);
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						cmd_q <= q_cmd;
						scan_q <= '0;
						flushed_q <= 1'b0;
						if (q_cmd.bad || q_cmd.action == ACT_PUT) begin
							out_handle <= '0;
							out_opcode <= '0;
							out_call_id <= '0;
							out_class <= q_cmd.req_class;
							last <= 1'b1;
							if (q_cmd.bad) begin
								status <= ST_BADCLASS;
								pending_count <= 5'(count_q);
							end else if (count_q == CNT_W'(ENTRIES)) begin
								status <= ST_FULL;
								pending_count <= 5'(count_q);
							end else begin
								status <= ST_OK;
								count_q <= count_q + 1'b1;
								pending_count <= 5'(count_q + 1'b1);
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_q < count_q && !match) begin
						scan_q <= scan_q + 1'b1;
					end else if (scan_q < count_q &&
						(cmd_q.action != ACT_CHECK ||
						({1'b0, slot_q[sidx].stamp} + {1'b0, timeout_sec}) <
						{1'b0, cmd_q.now_sec})) begin
						hit_slot_q <= slot_q[sidx];
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_EMIT;
						found_q <= 1'b0;
					end
				end
				S_SHIFT: begin
					if (scan_q + 1'b1 < count_q) scan_q <= scan_q + 1'b1;
					else begin
						count_q <= count_q - 1'b1;
						found_q <= 1'b1;
						state_q <= S_EMIT;
					end
				end
				default: begin
					// S_EMIT: if the output is free, deliver a result, or hold a flush hit, sending any prior one.
					if (free) begin
						if (cmd_q.action == ACT_FLUSH && found_q) begin
							if (held_q) begin
								status <= ST_ABORTED;
								{out_class, out_call_id, out_opcode, out_handle} <=
									{cmd_q.req_class, held_slot_q.call_id,
									held_slot_q.opcode, held_slot_q.handle};
								pending_count <= 5'(count_q + 1'b1);
								last <= 1'b0;
							end
							held_q <= 1'b1;
							held_slot_q <= hit_slot_q;
							flushed_q <= 1'b1;
							scan_q <= '0;
							state_q <= S_SCAN;
						end else if (cmd_q.action == ACT_FLUSH && flushed_q) begin
							status <= ST_ABORTED;
							{out_class, out_call_id, out_opcode, out_handle} <=
								{cmd_q.req_class, held_slot_q.call_id,
								held_slot_q.opcode, held_slot_q.handle};
							pending_count <= 5'(count_q);
							last <= 1'b1;
							held_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							status <= found_q ? ST_OK : ST_NONE;
							out_class <= cmd_q.req_class;
							out_handle <= found_q ? hit_slot_q.handle : '0;
							out_opcode <= found_q ? hit_slot_q.opcode : '0;
							out_call_id <= found_q ? hit_slot_q.call_id : '0;
							pending_count <= 5'(count_q);
							last <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
			endcase
		end
	end

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(ENTRIES);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("entry count overflow");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE) else $error("pop while busy");

	a_put_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |-> pending_count <= 5'(ENTRIES))
		else $error("pending count out of range");
endmodule

FILE: hw/rtl/outstanding_request_tracker.sv
// Outstanding request tracker. Up to 16 requests of three classes are held in
// arrival order in one store. Each input transaction is a put, a get by call
// id, a timeout check on the oldest entry of a class, or a flush of a class;
// it yields one result transaction, or one per entry removed by a flush, with
// last set on the final one. A front stage classifies transactions into a
// two-entry queue; the back stage works on one transaction at a time. A put
// or a bad class is answered as it is taken from the queue; a get or check
// searches one slot a cycle up to the hit and then compacts one slot a cycle
// from the hit to the end, so search and compaction together cover the store
// once; a flush repeats that search once per removed entry. timeout_sec may
// be written only while the block is idle.
module outstanding_request_tracker import ort_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [1:0] req_class,
	input logic [63:0] call_id,
	input logic [7:0] opcode,
	input logic [31:0] frame_handle,
	input logic [31:0] now_sec,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] status,
	output logic [31:0] out_handle,
	output logic [7:0] out_opcode,
	output logic [63:0] out_call_id,
	output logic [1:0] out_class,
	output logic [4:0] pending_count,
	output logic last
);
	logic [31:0] timeout_q;
	logic q_valid, q_pop;
	cmd_t q_cmd;

	// The timeout register resets to sixty seconds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) timeout_q <= 32'd60;
		else if (cfg_we) timeout_q <= cfg_wdata;
	end

	ort_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .req_class, .call_id,
		.opcode, .frame_handle, .now_sec, .q_valid, .q_pop, .q_cmd
	);

	ort_back u_back (
		.clk, .arst_n, .timeout_sec(timeout_q), .q_valid, .q_pop, .q_cmd,
		.out_valid, .out_stall, .status, .out_handle, .out_opcode,
		.out_call_id, .out_class, .pending_count, .last
	);
endmodule

FILE: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ort_pkg::*;

	// One row of the directed table. When chk is set, the last result the shadow
	// model expects for the transaction must carry the typed-in status and pending count.
	typedef struct {
		logic [1:0] act;
		logic [1:0] cls;
		logic [63:0] cid;
		logic [7:0] opc;
		logic [31:0] hdl;
		logic [31:0] now;
		bit chk;
		logic [2:0] st;
		logic [4:0] cnt;
	} row_t;

	// One result transaction as the block presents it.
	typedef struct {
		logic [2:0] st;
		logic [31:0] hdl;
		logic [7:0] opc;
		logic [63:0] cid;
		logic [1:0] cls;
		logic [4:0] cnt;
		logic lst;
	} res_t;

	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [1:0] req_class = '0;
	logic [63:0] call_id = '0;
	logic [7:0] opcode = '0;
	logic [31:0] frame_handle = '0;
	logic [31:0] now_sec = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [31:0] out_handle;
	logic [7:0] out_opcode;
	logic [63:0] out_call_id;
	logic [1:0] out_class;
	logic [4:0] pending_count;
	logic last;

	outstanding_request_tracker DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.req_class(req_class), .call_id(call_id), .opcode(opcode),
		.frame_handle(frame_handle), .now_sec(now_sec), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .out_handle(out_handle),
		.out_opcode(out_opcode), .out_call_id(out_call_id),
		.out_class(out_class), .pending_count(pending_count), .last(last)
	);

	always #5 clk = ~clk;

	// Shadow copy of the tracker: the compacted store, oldest entry at index 0.
	slot_t store[$];
	logic [31:0] timeout_shadow;
	res_t awaited[$];
	int mismatches = 0;
	int cycles = 0;
	bit stall_on = 1'b0;

	// Pushes the results one input transaction should produce, updating the
	// shadow store exactly as the tracker would.
	task automatic track_request(input logic [1:0] act, input logic [1:0] cls,
		input logic [63:0] cid, input logic [7:0] opc, input logic [31:0] hdl,
		input logic [31:0] now);
		res_t r;
		slot_t s;
		int idx;
		r = '{st: ST_NONE, hdl: '0, opc: '0, cid: '0, cls: cls, cnt: '0, lst: 1'b1};
		idx = -1;
		if (cls == CLASS_BAD) begin
			r.st = ST_BADCLASS;
		end else if (act == ACT_PUT) begin
			if (store.size() >= ENTRIES) begin
				r.st = ST_FULL;
			end else begin
				s = '{cls: cls, call_id: cid, opcode: opc, handle: hdl, stamp: now};
				store.push_back(s);
				r.st = ST_OK;
			end
		end else if (act == ACT_GET || act == ACT_CHECK) begin
			foreach (store[i])
				if (idx < 0 && store[i].cls == cls && (act != ACT_GET || store[i].call_id == cid))
					idx = i;
			// The timeout compare is done at 33 bits so it never wraps.
			if (idx >= 0 && act == ACT_CHECK &&
				!({1'b0, store[idx].stamp} + {1'b0, timeout_shadow} < {1'b0, now}))
				idx = -1;
			if (idx >= 0) begin
				r.st = ST_OK;
				r.hdl = store[idx].handle;
				r.opc = store[idx].opcode;
				r.cid = store[idx].call_id;
				store.delete(idx);
			end
		end else begin
			// Flush: one aborted result per entry of the class, oldest first, or one none result if there is none.
			for (int i = 0; i < store.size(); ) begin
				if (store[i].cls == cls) begin
					if (idx >= 0)
						awaited.push_back(r);
					r.st = ST_ABORTED;
					r.hdl = store[i].handle;
					r.opc = store[i].opcode;
					r.cid = store[i].call_id;
					store.delete(i);
					r.cnt = 5'(store.size());
					r.lst = 1'b0;
					idx = i;
				end else begin
					i++;
				end
			end
			r.lst = 1'b1;
			// Earlier flush results already carry their own pending count.
			if (idx >= 0) begin
				awaited.push_back(r);
				return;
			end
		end
		r.cnt = 5'(store.size());
		awaited.push_back(r);
	endtask

	// Fix the counts of intermediate flush results: each was captured at its
	// own removal, which is what the tracker reports, so nothing to do there.

	// Presents one transaction and waits until the tracker accepts it.
	task automatic send_request(input logic [1:0] act, input logic [1:0] cls,
		input logic [63:0] cid, input logic [7:0] opc, input logic [31:0] hdl,
		input logic [31:0] now);
		action <= act;
		req_class <= cls;
		call_id <= cid;
		opcode <= opc;
		frame_handle <= hdl;
		now_sec <= now;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		track_request(act, cls, cid, opc, hdl, now);
		@(negedge clk);
	endtask

	// Random gap between bursts; the valid is lowered only when a gap follows.
	task automatic sender_gap();
		int n;
		n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Waits until every expected result has arrived, then lets the block settle
	// before the timeout register is changed.
	task automatic set_timeout(input logic [31:0] val);
		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		timeout_shadow = val;
	endtask

	// Receiver: stalls on its own pattern, alternating quiet stretches with
	// busy ones, and checks each accepted result against the oldest expectation.
	always @(negedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 300 == 0)
			stall_on <= $urandom_range(0, 1);
		out_stall <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b0;
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result status=%0d handle=%h", $time, status,
					out_handle);
				mismatches++;
			end else begin
				e = awaited.pop_front();
				if (status !== e.st || out_handle !== e.hdl || out_opcode !== e.opc ||
					out_call_id !== e.cid || out_class !== e.cls ||
					pending_count !== e.cnt || last !== e.lst) begin
					$display("%0t: expected st=%0d hdl=%h opc=%h cid=%h cls=%0d cnt=%0d last=%b",
						$time, e.st, e.hdl, e.opc, e.cid, e.cls, e.cnt, e.lst);
					$display("%0t: actual   st=%0d hdl=%h opc=%h cid=%h cls=%0d cnt=%0d last=%b",
						$time, status, out_handle, out_opcode, out_call_id, out_class,
						pending_count, last);
					mismatches++;
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	row_t plan[$];
	res_t first;

	initial begin
		logic [1:0] a;
		logic [1:0] c;
		logic [63:0] id;
		logic [31:0] t;
		int k;
		int n_sent;
		timeout_shadow = 32'd60;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: expected status and count typed in where obvious.
		plan = '{
			'{ACT_GET, 2'd0, 64'd1, 8'd0, 32'd0, 32'd0, 1, ST_NONE, 5'd0},
			'{ACT_CHECK, 2'd1, 64'd0, 8'd0, 32'd0, 32'hFFFF_FFFF, 1, ST_NONE, 5'd0},
			'{ACT_FLUSH, 2'd2, 64'd0, 8'd0, 32'd0, 32'd0, 1, ST_NONE, 5'd0},
			'{ACT_PUT, CLASS_BAD, '1, '1, '1, '1, 1, ST_BADCLASS, 5'd0},
			'{ACT_FLUSH, CLASS_BAD, 64'd0, 8'd0, 32'd0, 32'd0, 1, ST_BADCLASS, 5'd0},
			'{ACT_PUT, 2'd0, '1, 8'hFF, '1, 32'd0, 1, ST_OK, 5'd1},
			'{ACT_PUT, 2'd1, 64'd0, 8'h00, 32'd0, 32'hFFFF_FFFF, 1, ST_OK, 5'd2},
			'{ACT_PUT, 2'd2, 64'h5555_AAAA_5555_AAAA, 8'hA5, 32'h1234_5678, 32'd100,
				1, ST_OK, 5'd3},
			'{ACT_PUT, 2'd0, 64'd7, 8'h11, 32'd77, 32'd10, 1, ST_OK, 5'd4},
			'{ACT_GET, 2'd0, 64'd7, 8'h99, 32'd0, 32'd0, 0, ST_OK, 5'd0},
			'{ACT_GET, 2'd1, 64'd9, 8'd0, 32'd0, 32'd0, 1, ST_NONE, 5'd3},
			'{ACT_CHECK, 2'd0, 64'd0, 8'd0, 32'd0, 32'd60, 1, ST_NONE, 5'd3},
			'{ACT_CHECK, 2'd0, 64'd0, 8'd0, 32'd0, 32'd61, 0, ST_OK, 5'd0},
			'{ACT_CHECK, 2'd1, 64'd0, 8'd0, 32'd0, 32'hFFFF_FFFF, 1, ST_NONE, 5'd2},
			'{ACT_CHECK, 2'd2, 64'd0, 8'd0, 32'd0, 32'd161, 0, ST_OK, 5'd0},
			'{ACT_FLUSH, 2'd1, 64'd0, 8'd0, 32'd0, 32'd0, 0, ST_ABORTED, 5'd0}
		};
		foreach (plan[i]) begin
			send_request(plan[i].act, plan[i].cls, plan[i].cid, plan[i].opc, plan[i].hdl,
				plan[i].now);
			if (plan[i].chk) begin
				first = awaited[awaited.size() - 1];
				if (first.st !== plan[i].st || first.cnt !== plan[i].cnt) begin
					$display("%0t: row %0d expected st=%0d cnt=%0d, model gives st=%0d cnt=%0d",
						$time, i, plan[i].st, plan[i].cnt, first.st, first.cnt);
					mismatches++;
				end
			end
		end

		// Fill the store to the brim, overflow it, then flush a mixed set.
		for (int i = 0; i < ENTRIES + 2; i++)
			send_request(ACT_PUT, 2'(i % 3), 64'(i), 8'(i), 32'(i), 32'(i));
		send_request(ACT_FLUSH, 2'd0, 64'd0, 8'd0, 32'd0, 32'd0);
		send_request(ACT_FLUSH, 2'd1, 64'd0, 8'd0, 32'd0, 32'd0);
		send_request(ACT_FLUSH, 2'd2, 64'd0, 8'd0, 32'd0, 32'd0);

		// Random phases under different timeouts, extremes among them.
		n_sent = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_timeout(32'd0);
				1: set_timeout(32'hFFFF_FFFF);
				2: set_timeout(32'd5);
				3: set_timeout($urandom);
				default: set_timeout(32'd60);
			endcase
			t = $urandom_range(0, 1000);
			if (ph == 1)
				t = 32'hFFFF_FF00;
			for (k = 0; k < 69; k++) begin
				sender_gap();
				// Mostly puts and gets of ids already held, so matches are common.
				a = $urandom_range(0, 9) < 4 ? ACT_PUT : 2'($urandom_range(1, 3));
				if ($urandom_range(0, 9) == 0)
					a = ACT_FLUSH;
				else if (a == ACT_FLUSH && $urandom_range(0, 3) != 0)
					a = ACT_GET;
				c = $urandom_range(0, 19) == 0 ? CLASS_BAD : 2'($urandom_range(0, 2));
				id = {$urandom, $urandom};
				if (a == ACT_GET && store.size() != 0 && $urandom_range(0, 3) != 0) begin
					id = store[$urandom_range(0, store.size() - 1)].call_id;
					c = store[0].cls;
				end else if ($urandom_range(0, 1) == 0) begin
					id = 64'($urandom_range(0, 3));
				end
				t = t + $urandom_range(0, ph == 2 ? 4 : 30);
				if ($urandom_range(0, 15) == 0)
					t = $urandom;
				send_request(a, c, id, 8'($urandom), $urandom, t);
				n_sent++;
			end
		end

		in_valid <= 1'b0;
		while (awaited.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
